>>> rtl/mmd_pkg.sv
package mmd_pkg;

    localparam int MAP_DEPTH   = 128;
    localparam int MAP_IDX_W   = $clog2(MAP_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 4;

    // status high nibbles
    localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
    localparam logic [3:0] ST_NOTE_ON   = 4'h9;
    localparam logic [3:0] ST_POLY      = 4'hA;
    localparam logic [3:0] ST_CC        = 4'hB;
    localparam logic [3:0] ST_PROGRAM   = 4'hC;
    localparam logic [3:0] ST_TOUCH     = 4'hD;
    localparam logic [3:0] ST_BEND      = 4'hE;
    localparam logic [3:0] ST_SYSTEM    = 4'hF;

    // realtime status bytes
    localparam logic [7:0] RT_CLOCK     = 8'hF8;
    localparam logic [7:0] RT_START     = 8'hFA;
    localparam logic [7:0] RT_CONTINUE  = 8'hFB;
    localparam logic [7:0] RT_STOP      = 8'hFC;

    localparam int FLAG_ON   = 0;
    localparam int FLAG_OFF  = 1;
    localparam int FLAG_CC   = 2;
    localparam int FLAG_BEND = 3;

    typedef enum logic [1:0] {
        FUNC_MSG   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_QUERY = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_MSG   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        KIND_NONE     = 4'd0,
        KIND_ON       = 4'd1,
        KIND_OFF      = 4'd2,
        KIND_CC       = 4'd3,
        KIND_PROGRAM  = 4'd4,
        KIND_BEND     = 4'd5,
        KIND_TOUCH    = 4'd6,
        KIND_POLY     = 4'd7,
        KIND_CLOCK    = 4'd8,
        KIND_START    = 4'd9,
        KIND_CONTINUE = 4'd10,
        KIND_STOP     = 4'd11
    } kind_t;

    typedef struct packed {
        op_t                  op;
        kind_t                kind;
        logic [3:0]           chan;
        logic [6:0]           num;
        logic [6:0]           val;
        logic [13:0]          bend;
        logic                 q_ok;
        logic [MAP_IDX_W-1:0] q_idx;
    } cmd_t;

endpackage

>>> rtl/mmd_front.sv
module mmd_front
    import mmd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [4:0]           cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [IN_USER_W-1:0] s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic [4:0] filter_reg;
    logic [7:0] status;
    logic [6:0] d1;
    logic [6:0] d2;
    logic [1:0] count;
    logic [7:0] qidx;
    logic       pass;
    kind_t      kind_c;
    logic [6:0] num_c;
    logic [6:0] val_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= 5'd0;
        end else if (cfg_wr_en) begin
            filter_reg <= cfg_wr_data;
        end
    end

    assign status = s_tdata[7:0];
    assign d1     = s_tdata[14:8];
    assign d2     = s_tdata[21:15];
    assign count  = s_tdata[23:22];
    assign qidx   = s_tdata[31:24];

    assign pass = (filter_reg == 5'd0) || ({1'b0, status[3:0]} + 5'd1 == filter_reg);

    always_comb begin
        kind_c = KIND_NONE;
        num_c  = 7'd0;
        val_c  = 7'd0;
        if (s_tuser == FUNC_MSG && pass && count != 2'd0) begin
            unique case (status[7:4])
                ST_NOTE_ON: begin
                    if (count == 2'd3) begin
                        kind_c = (d2 != 7'd0) ? KIND_ON : KIND_OFF;
                        num_c  = d1;
                        val_c  = d2;
                    end
                end
                ST_NOTE_OFF: begin
                    if (count == 2'd3) begin
                        kind_c = KIND_OFF;
                        num_c  = d1;
                        val_c  = d2;
                    end
                end
                ST_CC: begin
                    if (count == 2'd3) begin
                        kind_c = KIND_CC;
                        num_c  = d1;
                        val_c  = d2;
                    end
                end
                ST_PROGRAM: begin
                    if (count[1]) begin
                        kind_c = KIND_PROGRAM;
                        val_c  = d1;
                    end
                end
                ST_BEND: begin
                    if (count == 2'd3) begin
                        kind_c = KIND_BEND;
                    end
                end
                ST_TOUCH: begin
                    if (count[1]) begin
                        kind_c = KIND_TOUCH;
                        val_c  = d1;
                    end
                end
                ST_POLY: begin
                    if (count == 2'd3) begin
                        kind_c = KIND_POLY;
                        num_c  = d1;
                        val_c  = d2;
                    end
                end
                ST_SYSTEM: begin
                    if (status == RT_CLOCK) begin
                        kind_c = KIND_CLOCK;
                    end else if (status == RT_START) begin
                        kind_c = KIND_START;
                    end else if (status == RT_CONTINUE) begin
                        kind_c = KIND_CONTINUE;
                    end else if (status == RT_STOP) begin
                        kind_c = KIND_STOP;
                    end
                end
                default: begin
                    kind_c = KIND_NONE;
                end
            endcase
        end
    end

    always_comb begin
        unique case (s_tuser)
            FUNC_MSG:   q_cmd.op = OP_MSG;
            FUNC_CLEAR: q_cmd.op = OP_CLEAR;
            FUNC_QUERY: q_cmd.op = OP_QUERY;
            default:    q_cmd.op = OP_NOP;
        endcase
        q_cmd.kind  = kind_c;
        q_cmd.chan  = (kind_c != KIND_NONE) ? status[3:0] : 4'd0;
        q_cmd.num   = num_c;
        q_cmd.val   = val_c;
        // centred bend: code ^ 0x2000 flips the top bit
        q_cmd.bend  = {~d2[6], d2[5:0], d1};
        q_cmd.q_ok  = (s_tuser == FUNC_QUERY) && !qidx[7];
        q_cmd.q_idx = qidx[MAP_IDX_W-1:0];
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

>>> rtl/mmd_queue.sv
module mmd_queue
    import mmd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic avail,
    output cmd_t pop_cmd
);

    cmd_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] cnt_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign avail   = (cnt_reg != '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + QUEUE_PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/mmd_back.sv
module mmd_back
    import mmd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_avail,
    input  cmd_t                  q_cmd,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    logic [MAP_DEPTH-1:0] note_on_reg;
    logic [MAP_DEPTH-1:0] cc_seen_reg;
    logic [MAP_DEPTH-1:0] cc_written_reg;
    logic [6:0]           cc_mem [MAP_DEPTH];
    logic [6:0]           cc_rd_reg;
    logic [3:0]           flags_reg;
    logic [6:0]           note_reg;
    logic [6:0]           vel_reg;
    logic [13:0]          bend_reg;

    logic                 r_valid_reg;
    kind_t                r_kind_reg;
    logic [3:0]           r_chan_reg;
    logic [6:0]           r_num_reg;
    logic [6:0]           r_val_reg;
    logic                 r_qon_reg;
    logic                 r_qseen_reg;
    logic                 r_qwr_reg;
    logic [6:0]           q_val;

    assign q_pop = q_avail && (!r_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (q_pop && q_cmd.op == OP_MSG && q_cmd.kind == KIND_CC) begin
            cc_mem[q_cmd.num] <= q_cmd.val;
        end
        if (q_pop) begin
            cc_rd_reg <= cc_mem[q_cmd.q_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg    <= 1'b0;
            note_on_reg    <= '0;
            cc_seen_reg    <= '0;
            cc_written_reg <= '0;
            flags_reg      <= 4'd0;
            note_reg       <= 7'd0;
            vel_reg        <= 7'd0;
            bend_reg       <= 14'd0;
        end else begin
            if (q_pop) begin
                r_valid_reg <= 1'b1;
            end else if (m_tready) begin
                r_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                unique case (q_cmd.op)
                    OP_MSG: begin
                        case (q_cmd.kind)
                            KIND_ON: begin
                                flags_reg[FLAG_ON]     <= 1'b1;
                                note_on_reg[q_cmd.num] <= 1'b1;
                                note_reg               <= q_cmd.num;
                                vel_reg                <= q_cmd.val;
                            end
                            KIND_OFF: begin
                                flags_reg[FLAG_OFF] <= 1'b1;
                            end
                            KIND_CC: begin
                                flags_reg[FLAG_CC]        <= 1'b1;
                                cc_seen_reg[q_cmd.num]    <= 1'b1;
                                cc_written_reg[q_cmd.num] <= 1'b1;
                            end
                            KIND_BEND: begin
                                flags_reg[FLAG_BEND] <= 1'b1;
                                bend_reg             <= q_cmd.bend;
                            end
                            default: begin
                            end
                        endcase
                    end
                    OP_CLEAR: begin
                        note_on_reg <= '0;
                        cc_seen_reg <= '0;
                        flags_reg   <= 4'd0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            r_kind_reg  <= q_cmd.kind;
            r_chan_reg  <= q_cmd.chan;
            r_num_reg   <= q_cmd.num;
            r_val_reg   <= q_cmd.val;
            r_qon_reg   <= q_cmd.q_ok && note_on_reg[q_cmd.q_idx];
            r_qseen_reg <= q_cmd.q_ok && cc_seen_reg[q_cmd.q_idx];
            r_qwr_reg   <= q_cmd.q_ok && cc_written_reg[q_cmd.q_idx];
        end
    end

    assign q_val = r_qwr_reg ? cc_rd_reg : 7'd0;

    // held fields read live: no later item runs while this result waits
    assign m_tvalid = r_valid_reg;
    assign m_tuser  = r_kind_reg;
    assign m_tdata  = {5'd0, q_val, r_qseen_reg, r_qon_reg, vel_reg, note_reg,
                       flags_reg, bend_reg, r_val_reg, r_num_reg, r_chan_reg};

endmodule

>>> rtl/midi_message_decoder.sv
// Path: an accepted request passes the command queue, then the result register,
// before its result is presented.
// Throughput: one request per cycle while the queue is not full; the two-entry
// command queue and the result register let each side stall on its own.
// Reset: aresetn is synchronous and active low; it clears the channel filter,
// the queue, the note/cc maps, flags and held values.
module midi_message_decoder
    import mmd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [4:0]            cfg_wr_data,   // channel_filter
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // status_byte, data_first, data_second, byte_count, query_index
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,       // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // event_channel, event_number, event_value, held_bend, frame_flags,
    // last_note, last_velocity, query_note_on, query_cc_seen, query_cc_value
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser        // event_kind
);

    logic q_full;
    logic q_push;
    logic q_avail;
    logic q_pop;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    mmd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    mmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .pop_cmd  (pop_cmd)
    );

    mmd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_avail  (q_avail),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
